@@ rtl/rwrv_pkg.sv @@
// ----------------------------------------------------------------------------
// rwrv_pkg
// Shared types and constants for the ray/wall range voltage block.
// ----------------------------------------------------------------------------
package rwrv_pkg;

    localparam int MAX_WALLS_DEF = 64;

    localparam int COORD_W = 32;
    localparam int ENTRY_W = 4 * COORD_W;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;

    localparam logic [16:0] VOLT_OFFSET = 17'd111411;
    localparam logic [18:0] VOLT_SLOPE  = 19'd324403;
    localparam logic [16:0] VOLT_CLAMP  = 17'd117965;

    localparam logic [1:0] CFG_DIR_X  = 2'd0;
    localparam logic [1:0] CFG_DIR_Y  = 2'd1;
    localparam logic [1:0] CFG_COUNT  = 2'd2;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    typedef struct packed {
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic [COORD_W-1:0] end_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] start_x;
    } wall_t;

endpackage

@@ rtl/rwrv_mul.sv @@
// ----------------------------------------------------------------------------
// rwrv_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module rwrv_mul
    import rwrv_pkg::*;
(
    input  logic                     aclk,
    input  mul_req_t                 req,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= req.a * req.b;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/rwrv_table.sv @@
// ----------------------------------------------------------------------------
// rwrv_table
// Wall segment table, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rwrv_table
    import rwrv_pkg::*;
#(
    parameter int MAX_WALLS = MAX_WALLS_DEF,
    parameter int AW        = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  wall_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output wall_t         rd_data
);

    wall_t mem [MAX_WALLS];
    wall_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ray_wall_range_voltage.sv @@
// Measure word: the 18-step square root runs once, then for each wall in use the shared
//   multiplier forms the six products of three cross products, and for each wall that is
//   hit the 17-step divide runs.
// Throughput: one word at a time; s_tready is low while a measurement runs.
// Reset: aresetn synchronous active low; clears control and config registers,
//   the wall table itself is not cleared.
// ----------------------------------------------------------------------------
// ray_wall_range_voltage
// Ray cast against a table of wall segments, returning peak sensor voltage.
// ----------------------------------------------------------------------------
module ray_wall_range_voltage
    import rwrv_pkg::*;
#(
    parameter int MAX_WALLS = MAX_WALLS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // wall_index[5:0], wall_start_x, wall_start_y, wall_end_x, wall_end_y,
    // pos_x, pos_y (32 bits each), zero pad
    input  logic [199:0] s_tdata,
    // operation
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // voltage[16:0], any_hit[17], zero pad
    output logic [23:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CW = $clog2(MAX_WALLS + 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_SQX  = 5'd1;
    localparam logic [4:0] S_SQY  = 5'd2;
    localparam logic [4:0] S_SQS  = 5'd3;
    localparam logic [4:0] S_SQRT = 5'd4;
    localparam logic [4:0] S_RD   = 5'd5;
    localparam logic [4:0] S_LD   = 5'd6;
    localparam logic [4:0] S_M1   = 5'd7;
    localparam logic [4:0] S_M2   = 5'd8;
    localparam logic [4:0] S_M3   = 5'd9;
    localparam logic [4:0] S_M4   = 5'd10;
    localparam logic [4:0] S_M5   = 5'd11;
    localparam logic [4:0] S_M6   = 5'd12;
    localparam logic [4:0] S_M7   = 5'd13;
    localparam logic [4:0] S_CHK  = 5'd14;
    localparam logic [4:0] S_NORM = 5'd15;
    localparam logic [4:0] S_DIV  = 5'd16;
    localparam logic [4:0] S_DM   = 5'd17;
    localparam logic [4:0] S_DS   = 5'd18;
    localparam logic [4:0] S_VM   = 5'd19;
    localparam logic [4:0] S_VS   = 5'd20;
    localparam logic [4:0] S_NEXT = 5'd21;
    localparam logic [4:0] S_OUT  = 5'd22;

    // input fields
    logic [5:0]                wall_index;
    wall_t                     wall_in;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;

    assign wall_index      = s_tdata[5:0];
    assign wall_in.start_x = s_tdata[37:6];
    assign wall_in.start_y = s_tdata[69:38];
    assign wall_in.end_x   = s_tdata[101:70];
    assign wall_in.end_y   = s_tdata[133:102];
    assign pos_x           = s_tdata[165:134];
    assign pos_y           = s_tdata[197:166];

    logic [4:0]                state_reg, state_next;
    logic signed [15:0]        dir_x_reg, dir_y_reg;
    logic [6:0]                count_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic [CW-1:0]             idx_reg, nwalls_reg;
    logic [35:0]               sq_x_reg, sq_res_reg, sq_bit_reg;
    logic [17:0]               len_reg;
    logic signed [32:0]        ex_reg, ey_reg, wx_reg, wy_reg;
    logic signed [PROD_W-1:0]  acc_reg, den_reg, sn_reg, tn_reg;
    logic [51:0]               dabs_reg;
    logic [PROD_W-1:0]         tabs_reg;
    logic [47:0]               rem_reg, dsh_reg;
    logic [16:0]               q_reg;
    logic [4:0]                cnt_reg;
    logic [17:0]               dist_reg;
    logic [16:0]               max_reg;
    logic                      hit_reg;
    logic                      m_valid_reg;
    logic [16:0]               m_volt_reg;
    logic                      m_hit_reg;

    logic                      in_acc;
    logic                      wr_en;
    logic                      rd_en;
    wall_t                     rd_data;
    mul_req_t                  mreq;
    logic signed [PROD_W-1:0]  prod;
    logic signed [17:0]        dx, dy;

    assign dx = {dir_x_reg, 2'b00};
    assign dy = {dir_y_reg, 2'b00};

    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign wr_en     = in_acc && (s_tuser[0] == OP_WRITE)
                       && ({26'd0, wall_index} < 32'(MAX_WALLS));
    assign rd_en     = (state_reg == S_RD);
    assign cfg_ready = 1'b1;

    rwrv_table #(
        .MAX_WALLS (MAX_WALLS),
        .AW        (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(wall_index)),
        .wr_data (wall_in),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    rwrv_mul u_mul (
        .aclk (aclk),
        .req  (mreq),
        .prod (prod)
    );

    // multiplier operand select
    always_comb begin
        mreq.a = '0;
        mreq.b = '0;
        case (state_reg)
            S_SQX: begin
                mreq.a = MUL_W'(dir_x_reg);
                mreq.b = MUL_W'(dir_x_reg);
            end
            S_SQY: begin
                mreq.a = MUL_W'(dir_y_reg);
                mreq.b = MUL_W'(dir_y_reg);
            end
            S_M1: begin
                mreq.a = MUL_W'(dx);
                mreq.b = MUL_W'(ey_reg);
            end
            S_M2: begin
                mreq.a = MUL_W'(ex_reg);
                mreq.b = MUL_W'(dy);
            end
            S_M3: begin
                mreq.a = MUL_W'(dx);
                mreq.b = MUL_W'(wy_reg);
            end
            S_M4: begin
                mreq.a = MUL_W'(dy);
                mreq.b = MUL_W'(wx_reg);
            end
            S_M5: begin
                mreq.a = MUL_W'(ex_reg);
                mreq.b = MUL_W'(wy_reg);
            end
            S_M6: begin
                mreq.a = MUL_W'(ey_reg);
                mreq.b = MUL_W'(wx_reg);
            end
            S_DM: begin
                mreq.a = MUL_W'({1'b0, q_reg});
                mreq.b = MUL_W'({1'b0, len_reg});
            end
            S_VM: begin
                mreq.a = MUL_W'({1'b0, dist_reg});
                mreq.b = MUL_W'({1'b0, VOLT_SLOPE});
            end
            default: begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    // datapath helpers
    logic [36:0]              sq_trial;
    logic                     den_neg;
    logic signed [PROD_W-1:0] den_a, sn_a, tn_a;
    logic                     is_hit;
    logic [2:0]               shk;
    logic [48:0]              div_trial;
    logic signed [22:0]       volt;
    logic [6:0]               n_lim;

    assign sq_trial  = {1'b0, sq_x_reg} - ({1'b0, sq_res_reg} + {1'b0, sq_bit_reg});
    assign den_neg   = den_reg[PROD_W-1];
    assign den_a     = den_neg ? -den_reg : den_reg;
    assign sn_a      = den_neg ? -sn_reg  : sn_reg;
    assign tn_a      = den_neg ? -tn_reg  : tn_reg;
    assign is_hit    = (den_reg != '0) && !sn_a[PROD_W-1] && (sn_a <= den_a)
                       && !tn_a[PROD_W-1] && (tn_a <= den_a);
    assign div_trial = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign volt      = 23'($signed({6'd0, VOLT_OFFSET}))
                       - 23'($signed({1'b0, prod[37:16]}));
    assign n_lim     = ({25'd0, count_reg} > 32'(MAX_WALLS)) ? 7'(MAX_WALLS) : count_reg;

    always_comb begin
        if (dabs_reg[51])      shk = 3'd6;
        else if (dabs_reg[50]) shk = 3'd5;
        else if (dabs_reg[49]) shk = 3'd4;
        else if (dabs_reg[48]) shk = 3'd3;
        else if (dabs_reg[47]) shk = 3'd2;
        else if (dabs_reg[46]) shk = 3'd1;
        else                   shk = 3'd0;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_acc && (s_tuser[0] == OP_MEASURE)) state_next = S_SQX;
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = S_SQS;
            S_SQS:  state_next = S_SQRT;
            S_SQRT: begin
                if (sq_bit_reg == '0) begin
                    state_next = (nwalls_reg == '0) ? S_OUT : S_RD;
                end
            end
            S_RD:   state_next = S_LD;
            S_LD:   state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_M4;
            S_M4:   state_next = S_M5;
            S_M5:   state_next = S_M6;
            S_M6:   state_next = S_M7;
            S_M7:   state_next = S_CHK;
            S_CHK:  state_next = is_hit ? S_NORM : S_NEXT;
            S_NORM: state_next = S_DIV;
            S_DIV:  if (cnt_reg == 5'd16) state_next = S_DM;
            S_DM:   state_next = S_DS;
            S_DS:   state_next = S_VM;
            S_VM:   state_next = S_VS;
            S_VS:   state_next = S_NEXT;
            S_NEXT: state_next = (idx_reg + 1'b1 == nwalls_reg) ? S_OUT : S_RD;
            S_OUT:  if (!m_valid_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            dir_x_reg   <= 16'sd0;
            dir_y_reg   <= 16'sd16384;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DIR_X: dir_x_reg <= cfg_data;
                    CFG_DIR_Y: dir_y_reg <= cfg_data;
                    CFG_COUNT: count_reg <= cfg_data[6:0];
                    default:   ;
                endcase
            end
            if (state_reg == S_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                px_reg     <= pos_x;
                py_reg     <= pos_y;
                idx_reg    <= '0;
                nwalls_reg <= CW'(n_lim);
                max_reg    <= '0;
                hit_reg    <= 1'b0;
            end
            S_SQY: acc_reg <= prod;
            S_SQS: begin
                sq_x_reg   <= {(acc_reg[31:0] + prod[31:0]), 4'd0};
                sq_res_reg <= '0;
                sq_bit_reg <= 36'd1 << 34;
            end
            S_SQRT: begin
                if (sq_bit_reg != '0) begin
                    if (!sq_trial[36]) begin
                        sq_x_reg   <= sq_trial[35:0];
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                end else begin
                    len_reg <= sq_res_reg[17:0];
                end
            end
            S_LD: begin
                ex_reg <= 33'($signed(rd_data.end_x)) - 33'($signed(rd_data.start_x));
                ey_reg <= 33'($signed(rd_data.end_y)) - 33'($signed(rd_data.start_y));
                wx_reg <= 33'(px_reg) - 33'($signed(rd_data.start_x));
                wy_reg <= 33'(py_reg) - 33'($signed(rd_data.start_y));
            end
            S_M2: acc_reg <= prod;
            S_M3: den_reg <= acc_reg - prod;
            S_M4: acc_reg <= prod;
            S_M5: sn_reg  <= acc_reg - prod;
            S_M6: acc_reg <= prod;
            S_M7: tn_reg  <= acc_reg - prod;
            S_CHK: begin
                if (is_hit) begin
                    hit_reg  <= 1'b1;
                    dabs_reg <= den_a[51:0];
                    tabs_reg <= tn_a;
                end
            end
            S_NORM: begin
                dsh_reg <= 48'(dabs_reg >> shk);
                rem_reg <= 48'(tabs_reg[51:0] >> shk);
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            S_DIV: begin
                if (!div_trial[48]) begin
                    rem_reg <= {div_trial[46:0], 1'b0};
                    q_reg   <= {q_reg[15:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[46:0], 1'b0};
                    q_reg   <= {q_reg[15:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_DS: dist_reg <= prod[33:16];
            S_VS: begin
                if (volt > $signed({6'd0, max_reg})) begin
                    max_reg <= (volt < $signed({6'd0, VOLT_CLAMP})) ? volt[16:0] : VOLT_CLAMP;
                end
            end
            S_NEXT: idx_reg <= idx_reg + 1'b1;
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_volt_reg <= max_reg;
                    m_hit_reg  <= hit_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_hit_reg, m_volt_reg};

endmodule
